@@ rtl/button_edge_hold_tracker_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the button edge / hold tracker.
// Each macro expands to one labeled concurrent assertion on clk, disabled
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUTTON_EDGE_HOLD_TRACKER_CORE_DEFINES_SVH
`define BUTTON_EDGE_HOLD_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication
`define BEHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BEHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/beht_pkg.sv @@
// ---------------------------------------------------------------------------
// beht_pkg
// Shared types and constants for the button edge / hold tracker.
// ---------------------------------------------------------------------------
package beht_pkg;

  // Default pad size and counter width
  localparam int unsigned NUM_BUTTONS_DEF = 32;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned MASK_W          = 32;

  localparam logic [CNT_W-1:0] HOLD_ALL_ONES = {CNT_W{1'b1}};

  // Request operation codes
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_DECR   = 2'd2;

  // One request
  typedef struct packed {
    logic [1:0]        mode;
    logic [MASK_W-1:0] button_mask;
    logic [CNT_W-1:0]  amount;
  } beht_req_t;

  // One result
  typedef struct packed {
    logic             was_pressed;
    logic             was_held;
    logic             was_released;
    logic [CNT_W-1:0] held_for;
  } beht_rsp_t;

endpackage

@@ rtl/button_edge_hold_tracker_core.sv @@
// ---------------------------------------------------------------------------
// button_edge_hold_tracker_core
// Edge and hold-time tracker for a pad of NUM_BUTTONS buttons.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then walks
// the hold counters in its memory, one counter per cycle, each written back in
// the cycle after its read, and shows the result on out_rsp for exactly one
// cycle with out_valid high once the last counter has passed the modify stage.
// Every request, including update and decrement, gives one result; non-query
// results are all zero. busy stays high until the result is shown, so a new
// request is not taken while a walk is in progress, but can be taken in the
// same cycle the previous result is shown. The counter memory has a single
// read and a single write port. There is no back-pressure on the result side:
// the receiver must take out_rsp whenever out_valid is high. Counters wrap
// modulo 2^32 on update and saturate at zero on decrement; mask bits at or
// above NUM_BUTTONS are ignored.
// ---------------------------------------------------------------------------
module button_edge_hold_tracker_core #(
  parameter int unsigned NUM_BUTTONS = beht_pkg::NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  beht_pkg::beht_req_t in_req,
  output logic                out_valid,
  output beht_pkg::beht_rsp_t out_rsp
);
  import beht_pkg::*;

  `include "button_edge_hold_tracker_core_defines.svh"

  localparam int unsigned IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t                 state_r;
  logic [1:0]             mode_r;
  logic [NUM_BUTTONS-1:0] mask_r;
  logic [CNT_W-1:0]       amt_r;
  logic [NUM_BUTTONS-1:0] cur_r;
  logic [NUM_BUTTONS-1:0] prev_r;
  logic [NUM_BUTTONS-1:0] valid_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   s2_vld_r;
  logic [IDX_W-1:0]       s2_idx_r;
  logic [CNT_W-1:0]       rdata_r;
  logic [CNT_W-1:0]       min_r;
  logic                   out_valid_r;
  beht_rsp_t              out_rsp_r;

  // Hold counter memory
  logic [CNT_W-1:0] mem [NUM_BUTTONS];

  logic                   accept;
  logic [NUM_BUTTONS-1:0] in_mask;
  logic [CNT_W-1:0]       cnt;
  logic                   bit_m;
  logic                   bit_p;
  logic                   wr_en;
  logic [CNT_W-1:0]       wr_data;
  logic [CNT_W-1:0]       min_nxt;
  logic                   now_all;
  logic                   before_all;
  logic                   s2_last;
  beht_rsp_t              rsp_nxt;

  assign accept  = start && (state_r == ST_IDLE);
  assign in_mask = in_req.button_mask[NUM_BUTTONS-1:0];

  // Modify stage: counter read in the previous cycle, unwritten entries read as zero
  always_comb begin
    cnt     = valid_r[s2_idx_r] ? rdata_r : '0;
    bit_m   = mask_r[s2_idx_r];
    bit_p   = prev_r[s2_idx_r];
    wr_en   = 1'b0;
    wr_data = '0;
    case (mode_r)
      MODE_UPDATE: begin
        wr_en   = s2_vld_r && bit_m;
        wr_data = bit_p ? (cnt + amt_r) : '0;
      end
      MODE_DECR: begin
        wr_en   = s2_vld_r && bit_m;
        wr_data = (cnt > amt_r) ? (cnt - amt_r) : '0;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = '0;
      end
    endcase
  end

  // Running minimum for queries
  always_comb begin
    min_nxt = min_r;
    if (s2_vld_r && (mode_r == MODE_QUERY) && bit_m && (cnt < min_r)) begin
      min_nxt = cnt;
    end
  end

  // Result fields
  assign now_all    = (cur_r & mask_r) == mask_r;
  assign before_all = (prev_r & mask_r) == mask_r;
  assign s2_last    = s2_vld_r && (s2_idx_r == LAST_IDX);

  always_comb begin
    rsp_nxt = '0;
    if (mode_r == MODE_QUERY) begin
      rsp_nxt.was_pressed  = now_all && !before_all;
      rsp_nxt.was_held     = now_all && before_all;
      rsp_nxt.was_released = !now_all && before_all;
      rsp_nxt.held_for     = min_nxt;
    end
  end

  // Sequencer, masks, valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      prev_r      <= '0;
      valid_r     <= '0;
    end else begin
      // strobe for one cycle once the last counter has passed the modify stage
      out_valid_r <= (state_r == ST_DRAIN) && s2_last;
      s2_vld_r    <= (state_r == ST_RUN);
      s2_idx_r    <= rd_idx_r;
      min_r       <= accept ? HOLD_ALL_ONES : min_nxt;
      if (wr_en) begin
        valid_r[s2_idx_r] <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mode_r   <= in_req.mode;
            mask_r   <= in_mask;
            amt_r    <= in_req.amount;
            rd_idx_r <= '0;
            state_r  <= ST_RUN;
            if (in_req.mode == MODE_UPDATE) begin
              prev_r <= cur_r;
              cur_r  <= in_mask;
            end
          end
        end
        ST_RUN: begin
          rd_idx_r <= IDX_W'(rd_idx_r + 1'b1);
          if (rd_idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s2_last) begin
            out_rsp_r <= rsp_nxt;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_idx_r] <= wr_data;
    end
  end

  // Memory read port, registered data
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_idx_r];
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Checks
  `BEHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `BEHT_ASSERT_NEXT(a_single_result, out_valid, !out_valid, "result strobe held for two cycles")
  `BEHT_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while still busy")
  `BEHT_ASSERT_NOW(a_wr_in_walk, wr_en, s2_vld_r, "counter write outside the walk")
  `BEHT_ASSERT_NOW(a_idle_no_stage, state_r == ST_IDLE, !s2_vld_r, "modify stage active in idle")

endmodule

@@ tb/beht_checker.sv @@
// ---------------------------------------------------------------------------
// beht_checker
// Watches the request and result channels of the button edge / hold tracker,
// keeps its own copy of the button masks and hold counters, and checks every
// result field against the prediction for the oldest outstanding request.
// ---------------------------------------------------------------------------
module beht_checker #(
  parameter int unsigned NUM_BUTTONS = beht_pkg::NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  beht_pkg::beht_req_t in_req,
  input  logic                out_valid,
  input  beht_pkg::beht_rsp_t out_rsp,
  output int unsigned         mismatch_count,
  output int unsigned         pending_count
);
  import beht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Buttons that exist on the pad
  localparam logic [MASK_W-1:0] PAD_BITS = {MASK_W{1'b1}} >> (MASK_W - NUM_BUTTONS);

  logic [MASK_W-1:0] pad_now;
  logic [MASK_W-1:0] pad_before;
  logic [CNT_W-1:0]  hold_cnt [NUM_BUTTONS];
  beht_rsp_t         expected_rsp_q [$];
  int unsigned       errors = 0;

  // Apply one request to the tracked pad state and work out its result
  task automatic track_request(input beht_req_t req, output beht_rsp_t rsp);
    logic [MASK_W-1:0] mask;
    logic              now_all;
    logic              before_all;
    mask = req.button_mask & PAD_BITS;
    rsp  = '0;
    case (req.mode)
      MODE_UPDATE: begin
        pad_before = pad_now;
        pad_now    = mask;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (pad_now[b]) begin
            // held buttons accumulate (wrapping), new presses restart at zero
            hold_cnt[b] = pad_before[b] ? hold_cnt[b] + req.amount : '0;
          end
        end
      end
      MODE_QUERY: begin
        now_all          = (pad_now & mask) == mask;
        before_all       = (pad_before & mask) == mask;
        rsp.was_pressed  = now_all && !before_all;
        rsp.was_held     = now_all && before_all;
        rsp.was_released = !now_all && before_all;
        rsp.held_for     = HOLD_ALL_ONES;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (mask[b] && hold_cnt[b] < rsp.held_for) rsp.held_for = hold_cnt[b];
        end
      end
      MODE_DECR: begin
        // saturating subtract on the addressed counters
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (mask[b]) hold_cnt[b] = (hold_cnt[b] > req.amount) ? hold_cnt[b] - req.amount : '0;
        end
      end
      default: ;
    endcase
  endtask

  // Channel monitor: compare results first, then log the new request
  always @(posedge clk) begin : monitor
    beht_rsp_t want;
    if (!rst_n) begin
      pad_now    = '0;
      pad_before = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) hold_cnt[b] = '0;
      expected_rsp_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result with no request pending, actual %p", $time, out_rsp);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp.was_pressed !== want.was_pressed) begin
            $display("%0t: was_pressed expected %0b actual %0b",
                     $time, want.was_pressed, out_rsp.was_pressed);
            errors++;
          end
          if (out_rsp.was_held !== want.was_held) begin
            $display("%0t: was_held expected %0b actual %0b",
                     $time, want.was_held, out_rsp.was_held);
            errors++;
          end
          if (out_rsp.was_released !== want.was_released) begin
            $display("%0t: was_released expected %0b actual %0b",
                     $time, want.was_released, out_rsp.was_released);
            errors++;
          end
          if (out_rsp.held_for !== want.held_for) begin
            $display("%0t: held_for expected 0x%08h actual 0x%08h",
                     $time, want.held_for, out_rsp.held_for);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        track_request(in_req, want);
        expected_rsp_q.push_back(want);
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_rsp_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the button edge / hold tracker: a directed run
// over edges, wrap, saturation and empty masks, then random pad frames with
// queries and decrements, with random gaps between requests.
// ---------------------------------------------------------------------------
module tb_top;
  import beht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQS = 1550;

  logic        clk;
  logic        rst_n  = 1'b0;
  logic        start  = 1'b0;
  beht_req_t   in_req = '0;
  logic        busy;
  logic        out_valid;
  beht_rsp_t   out_rsp;
  int unsigned mismatch_count;
  int unsigned pending_count;

  // Last two pad samples sent, used to shape queries and decrements
  logic [MASK_W-1:0] frame_mask      = '0;
  logic [MASK_W-1:0] frame_mask_prev = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  button_edge_hold_tracker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  beht_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_rsp        (out_rsp),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Hold a request on the port until the block takes it
  task automatic issue(input logic [1:0] mode, input logic [MASK_W-1:0] mask,
                       input logic [CNT_W-1:0] amount);
    in_req <= '{mode: mode, button_mask: mask, amount: amount};
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (mode == MODE_UPDATE) begin
      frame_mask_prev = frame_mask;
      frame_mask      = mask;
    end
  endtask

  task automatic pause_req(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly plausible pad frames; a few fully random requests as noise
  task automatic random_req();
    int unsigned       sel;
    logic [1:0]        mode;
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  amount;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      mode = MODE_UPDATE;
      mask = frame_mask;
      case ($urandom_range(0, 5))
        0:       mask = $urandom;
        1:       ;
        2, 3:    mask = mask ^ (32'h1 << $urandom_range(0, 31));
        4:       mask = mask ^ ($urandom & $urandom);
        default: mask = $urandom_range(0, 1) ? '1 : '0;
      endcase
      amount = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    end else if (sel < 80) begin
      mode   = MODE_QUERY;
      amount = $urandom;
      case ($urandom_range(0, 7))
        0:       mask = frame_mask & $urandom;
        1:       mask = frame_mask_prev & $urandom;
        2:       mask = 32'h1 << $urandom_range(0, 31);
        3:       mask = frame_mask;
        4:       mask = frame_mask_prev;
        5:       mask = '0;
        6:       mask = $urandom;
        default: mask = frame_mask | frame_mask_prev;
      endcase
    end else if (sel < 93) begin
      mode   = MODE_DECR;
      mask   = $urandom_range(0, 1) ? frame_mask : $urandom;
      amount = $urandom_range(0, 1) ? $urandom_range(0, 500) : $urandom;
    end else begin
      mode   = 2'($urandom_range(0, 3));
      mask   = $urandom;
      amount = $urandom;
    end
    issue(mode, mask, amount);
  endtask

  // Main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty and full queries straight after reset
    issue(MODE_QUERY,  32'h0000_0000, 32'h0000_0000);
    issue(MODE_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // all pressed, then held with a wrapping count
    issue(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0000_0005);
    issue(MODE_QUERY,  32'hFFFF_FFFF, 32'h0000_0000);
    issue(MODE_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    issue(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0000_0020);
    issue(MODE_QUERY,  32'hFFFF_FFFF, 32'h0000_0000);
    // upper half released, lower half held on
    issue(MODE_UPDATE, 32'h0000_FFFF, 32'h0000_0064);
    issue(MODE_QUERY,  32'hFFFF_0000, 32'h0000_0000);
    issue(MODE_QUERY,  32'h8000_0001, 32'h0000_0000);
    issue(MODE_QUERY,  32'h0000_FFFF, 32'h0000_0000);
    // decrement: partial, saturating, and by zero
    issue(MODE_DECR,   32'h0000_00FF, 32'h0000_0032);
    issue(MODE_DECR,   32'h0000_000F, 32'hFFFF_FFFF);
    issue(MODE_DECR,   32'hFFFF_FFFF, 32'h0000_0000);
    issue(MODE_QUERY,  32'h0000_0001, 32'h0000_0000);
    issue(MODE_QUERY,  32'h0000_00F0, 32'h0000_0000);
    issue(MODE_QUERY,  32'h0001_0000, 32'h0000_0000);
    // unused mode changes nothing
    issue(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(MODE_QUERY,  32'hFFFF_FFFF, 32'h0000_0000);
    // release everything, then alternating patterns
    issue(MODE_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(MODE_QUERY,  32'h0000_0000, 32'h0000_0000);
    issue(MODE_UPDATE, 32'hAAAA_AAAA, 32'h0000_0001);
    issue(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0000_0007);
    issue(MODE_QUERY,  32'h5555_5555, 32'h0000_0000);
    issue(MODE_QUERY,  32'hAAAA_AAAA, 32'h0000_0000);

    // random frames; a stretch in the middle runs without gaps
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (!(i >= 600 && i < 900) && $urandom_range(0, 99) < 12)
        pause_req($urandom_range(1, 40));
      random_req();
    end

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ button_edge_hold_tracker_core.f @@
+incdir+rtl
rtl/beht_pkg.sv
rtl/button_edge_hold_tracker_core.sv
tb/beht_checker.sv
tb/tb_top.sv
